/* hw/rtl/arp_cache_resolver_macros.svh */
// Assertion macros shared by the ARP cache resolver RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ARP_CACHE_RESOLVER_MACROS_SVH
`define ARP_CACHE_RESOLVER_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is high.
`define ARPC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
// Next-cycle implication, disabled while reset is high.
`define ARPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ARPC_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ARPC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/arpc_pkg.sv */
// Package for the ARP cache resolver: types, codes and protocol constants.
// No dependencies; used by the cache cell, the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none
package arpc_pkg;

   localparam int ARPC_CACHE_ENTRIES = 8;

   localparam logic [15:0] ARP_OP_REQUEST     = 16'd1;
   localparam logic [15:0] ARP_OP_RESPONSE    = 16'd2;
   localparam logic [15:0] ARP_HTYPE_ETHERNET = 16'd1;
   localparam logic [15:0] ARP_PTYPE_IPV4     = 16'h0800;
   localparam logic [10:0] ARP_MIN_LEN        = 11'd28;

   typedef enum logic [2:0] {
      STAT_RESOLVED = 3'd0,
      STAT_REQUEST  = 3'd1,
      STAT_REPLY    = 3'd2,
      STAT_UPDATED  = 3'd3,
      STAT_IGNORED  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CSR_OWN_IP      = 2'd0,
      CSR_OWN_MAC     = 2'd1,
      CSR_SUBNET_MASK = 2'd2,
      CSR_GATEWAY_IP  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUTE,
      ST_SEARCH,
      ST_DONE
   } state_type;

   // Lookup token that walks the cell chain.
   typedef struct packed {
      logic        valid;
      logic        found;
      logic [31:0] key;
      logic [47:0] mac;
   } probe_type;

   // Entry data broadcast to all cells on insertion.
   typedef struct packed {
      logic [31:0] ip;
      logic [47:0] mac;
   } entry_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] dest_ip;
      logic [10:0] msg_len;
      logic [15:0] hw_type;
      logic [15:0] ptype;
      logic [15:0] op_code;
      logic [47:0] sender_mac;
      logic [31:0] sender_ip;
      logic [31:0] target_ip;
   } req_item_type;

endpackage
`default_nettype wire

/* hw/rtl/arpc_if.sv */
// Request and response channel interfaces of the ARP cache resolver.
// Depends on arpc_pkg for nothing but shares its field widths.
`timescale 1ns / 1ps
`default_nettype none
interface arpc_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [31:0] dest_ip;
   logic [10:0] msg_len;
   logic [15:0] hw_type;
   logic [15:0] ptype;
   logic [15:0] op_code;
   logic [47:0] sender_mac;
   logic [31:0] sender_ip;
   logic [31:0] target_ip;

   modport source (output valid, kind, dest_ip, msg_len, hw_type, ptype, op_code,
                   sender_mac, sender_ip, target_ip, input ready);
   modport sink   (input valid, kind, dest_ip, msg_len, hw_type, ptype, op_code,
                   sender_mac, sender_ip, target_ip, output ready);
endinterface

interface arpc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [47:0] mac_out;
   logic [31:0] ip_out;

   modport source (output valid, status, mac_out, ip_out, input ready);
   modport sink   (input valid, status, mac_out, ip_out, output ready);
endinterface
`default_nettype wire

/* hw/rtl/arpc_cell.sv */
// One ARP cache cell: holds a single IP/MAC pair and passes the lookup token on.
// Depends on arpc_pkg (probe_type, entry_type).
`timescale 1ns / 1ps
`default_nettype none
module arpc_cell
   import arpc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  probe_type prev_probe,
   output probe_type next_probe,
   input  logic      wr_en,
   input  entry_type wr_entry
);

   logic [31:0] entry_ip_ff;
   logic [47:0] entry_mac_ff;
   probe_type   probe_ff;
   probe_type   probe_in;

   // Claim the token on the first match only; earlier cells win.
   always_comb begin
      probe_in = prev_probe;
      if (prev_probe.valid && !prev_probe.found && (prev_probe.key == entry_ip_ff)) begin
         probe_in.found = 1'b1;
         probe_in.mac   = entry_mac_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ip_ff  <= '0;
         entry_mac_ff <= '0;
      end else if (wr_en) begin
         entry_ip_ff  <= wr_entry.ip;
         entry_mac_ff <= wr_entry.mac;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff.valid <= 1'b0;
      end else begin
         probe_ff.valid <= probe_in.valid;
      end
      probe_ff.found <= probe_in.found;
      probe_ff.key   <= probe_in.key;
      probe_ff.mac   <= probe_in.mac;
   end

   assign next_probe = probe_ff;

endmodule
`default_nettype wire

/* hw/rtl/arp_cache_resolver.sv */
// Top level of the ARP cache resolver: control sequencer, cell chain, output register.
// Depends on arpc_pkg, arpc_if, arpc_cell and arp_cache_resolver_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "arp_cache_resolver_macros.svh"
// The resolver keeps CACHE_ENTRIES IPv4-to-MAC pairs, all zero after reset, in a row of
// cells and takes one item at a time. A resolve item picks its next hop (the destination
// itself when on the local subnet, else the gateway) and returns the cached MAC or asks
// for an ARP request. A received ARP message for our IP with a valid length, Ethernet
// hardware type and IPv4 protocol type yields reply fields (request) or, when the sender
// is not cached yet, an insertion at the round-robin write pointer (response). Every
// item gives exactly one result. A lookup token walks the cell chain one cell per cycle,
// so an item that needs the table goes through the route state, the whole chain, the
// search state and the done state before its result is registered; other items go
// from the route state straight to the done state. The next item is accepted once the
// result has left the done state. The result waits in an output register, and the next
// item is accepted while it waits.
module arp_cache_resolver
   import arpc_pkg::*;
#(
   parameter int CACHE_ENTRIES = ARPC_CACHE_ENTRIES
) (
   input  logic              clock,
   input  logic              reset,
   arpc_req_if.sink          req_chan,
   arpc_rsp_if.source        rsp_chan,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [47:0]       csr_wdata
);

   localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

   // Configuration registers.
   logic [31:0] own_ip_ff;
   logic [31:0] subnet_mask_ff;
   logic [31:0] gateway_ip_ff;

   // Sequencer state and item hold registers.
   state_type    state_ff, state_in;
   req_item_type item_ff, item_in;
   status_type   pend_status_ff, pend_status_in;
   logic [47:0]  pend_mac_ff, pend_mac_in;
   logic [31:0]  pend_ip_ff, pend_ip_in;
   logic         ins_ff, ins_in;
   logic [IDX_W-1:0] wp_ff, wp_in;

   // Output register.
   logic         rsp_valid_ff, rsp_valid_in;
   status_type   rsp_status_ff, rsp_status_in;
   logic [47:0]  rsp_mac_ff, rsp_mac_in;
   logic [31:0]  rsp_ip_ff, rsp_ip_in;

   // Cell chain.
   probe_type          chain [0:CACHE_ENTRIES];
   probe_type          launch_probe;
   logic [CACHE_ENTRIES-1:0] cell_wr_en;
   entry_type          wr_entry;
   logic               wr_req;

   logic        req_fire;
   logic        on_subnet;
   logic [31:0] next_hop;
   logic        msg_ok;
   probe_type   chain_out;

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign chain[0]  = launch_probe;
   assign chain_out = chain[CACHE_ENTRIES];

   // Next-hop choice and acceptance checks work from the held item.
   assign on_subnet = (((item_ff.dest_ip ^ own_ip_ff) & subnet_mask_ff) == 32'd0);
   assign next_hop  = on_subnet ? item_ff.dest_ip : gateway_ip_ff;
   assign msg_ok    = (item_ff.msg_len >= ARP_MIN_LEN) &&
                      (item_ff.hw_type == ARP_HTYPE_ETHERNET) &&
                      (item_ff.ptype == ARP_PTYPE_IPV4) &&
                      (item_ff.target_ip == own_ip_ff);

   // Configuration writes; there is no MAC register here, so writes to the own-MAC index are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff      <= '0;
         subnet_mask_ff <= '0;
         gateway_ip_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_OWN_IP:      own_ip_ff      <= csr_wdata[31:0];
            CSR_OWN_MAC:     ;
            CSR_SUBNET_MASK: subnet_mask_ff <= csr_wdata[31:0];
            CSR_GATEWAY_IP:  gateway_ip_ff  <= csr_wdata[31:0];
            default:         ;
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      item_in        = item_ff;
      pend_status_in = pend_status_ff;
      pend_mac_in    = pend_mac_ff;
      pend_ip_in     = pend_ip_ff;
      ins_in         = ins_ff;
      wp_in          = wp_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_mac_in     = rsp_mac_ff;
      rsp_ip_in      = rsp_ip_ff;
      rsp_valid_in   = rsp_chan.ready ? 1'b0 : rsp_valid_ff;
      launch_probe   = '0;
      wr_req         = 1'b0;
      wr_entry.ip    = item_ff.sender_ip;
      wr_entry.mac   = item_ff.sender_mac;

      unique case (state_ff)
         ST_IDLE: begin
            // Hold the accepted item for the whole walk.
            if (req_fire) begin
               item_in.kind       = req_chan.kind;
               item_in.dest_ip    = req_chan.dest_ip;
               item_in.msg_len    = req_chan.msg_len;
               item_in.hw_type    = req_chan.hw_type;
               item_in.ptype      = req_chan.ptype;
               item_in.op_code    = req_chan.op_code;
               item_in.sender_mac = req_chan.sender_mac;
               item_in.sender_ip  = req_chan.sender_ip;
               item_in.target_ip  = req_chan.target_ip;
               state_in           = ST_ROUTE;
            end
         end
         ST_ROUTE: begin
            pend_status_in = STAT_IGNORED;
            pend_mac_in    = '0;
            pend_ip_in     = '0;
            ins_in         = 1'b0;
            priority if (!item_ff.kind) begin
               // Launch a lookup of the next hop.
               launch_probe.valid = 1'b1;
               launch_probe.key   = next_hop;
               pend_ip_in         = next_hop;
               state_in           = ST_SEARCH;
            end else if (msg_ok && (item_ff.op_code == ARP_OP_REQUEST)) begin
               pend_status_in = STAT_REPLY;
               pend_mac_in    = item_ff.sender_mac;
               pend_ip_in     = item_ff.sender_ip;
               state_in       = ST_DONE;
            end else if (msg_ok && (item_ff.op_code == ARP_OP_RESPONSE)) begin
               // Check the sender for presence before inserting.
               launch_probe.valid = 1'b1;
               launch_probe.key   = item_ff.sender_ip;
               state_in           = ST_SEARCH;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SEARCH: begin
            // Wait for the token to leave the last cell.
            if (chain_out.valid) begin
               if (!item_ff.kind) begin
                  pend_status_in = chain_out.found ? STAT_RESOLVED : STAT_REQUEST;
                  pend_mac_in    = chain_out.found ? chain_out.mac : 48'd0;
               end else begin
                  pend_status_in = chain_out.found ? STAT_IGNORED : STAT_UPDATED;
                  ins_in         = !chain_out.found;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Load the output register once it is free or being emptied.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_mac_in    = pend_mac_ff;
               rsp_ip_in     = pend_ip_ff;
               if (ins_ff) begin
                  wr_req = 1'b1;
                  wp_in  = (wp_ff == IDX_W'(CACHE_ENTRIES - 1)) ? '0 : IDX_W'(wp_ff + 1'b1);
               end
               ins_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ins_ff       <= 1'b0;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ins_ff       <= ins_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff        <= item_in;
      pend_status_ff <= pend_status_in;
      pend_mac_ff    <= pend_mac_in;
      pend_ip_ff     <= pend_ip_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_mac_ff     <= rsp_mac_in;
      rsp_ip_ff      <= rsp_ip_in;
   end

   // Row of cells; the token advances one cell per cycle, lowest match wins.
   for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
      assign cell_wr_en[g] = wr_req && (wp_ff == IDX_W'(g));
      arpc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .prev_probe (chain[g]),
         .next_probe (chain[g+1]),
         .wr_en      (cell_wr_en[g]),
         .wr_entry   (wr_entry)
      );
   end

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.status  = rsp_status_ff;
   assign rsp_chan.mac_out = rsp_mac_ff;
   assign rsp_chan.ip_out  = rsp_ip_ff;

   // A token only leaves the chain while the sequencer waits for it.
   `ARPC_ASSERT_IMPLIES(a_token_in_search, clock, reset, chain_out.valid, state_ff == ST_SEARCH)
   // Table writes happen only when a result is handed to the output register.
   `ARPC_ASSERT_NEXT(a_insert_with_result, clock, reset, wr_req, rsp_valid_ff && (rsp_status_ff == STAT_UPDATED))
   // The write pointer moves only on an insertion.
   `ARPC_ASSERT_NEXT(a_wp_moves_on_insert, clock, reset, !wr_req, $stable(wp_ff))

endmodule
`default_nettype wire

/* tb/arp_cache_resolver_checker.sv */
`timescale 1ns / 1ps
// Result checker for the ARP cache resolver: predicts every result and compares.
// Depends on arpc_pkg and the channel interfaces in arpc_if.
module arp_cache_resolver_checker
   import arpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   arpc_req_if         req_chan,
   arpc_rsp_if         rsp_chan,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_wdata,
   output int          fail_count,
   output int          outstanding
);

   localparam int CACHE_ENTRIES = ARPC_CACHE_ENTRIES;

   typedef struct packed {
      status_type  status;
      logic [47:0] mac;
      logic [31:0] ip;
   } arp_outcome_type;

   logic [31:0] own_ip;
   logic [31:0] subnet_mask;
   logic [31:0] gateway_ip;

   logic [31:0] cache_ip  [CACHE_ENTRIES];
   logic [47:0] cache_mac [CACHE_ENTRIES];
   int          next_slot;

   arp_outcome_type awaited_outcomes [$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   // Lowest-numbered entry holding ip, or -1.
   function automatic int find_entry(logic [31:0] ip);
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
         if (cache_ip[i] == ip) return i;
      end
      return -1;
   endfunction

   // Work out the result of one item and update the table on insertion.
   function automatic arp_outcome_type arp_outcome(req_item_type it);
      arp_outcome_type res;
      logic [31:0]     route;
      int              hit;
      logic            fields_ok;
      res = '{status: STAT_IGNORED, mac: '0, ip: '0};
      if (it.kind == 1'b0) begin
         route = (((it.dest_ip ^ own_ip) & subnet_mask) == 32'd0) ? it.dest_ip : gateway_ip;
         hit = find_entry(route);
         res.ip = route;
         if (hit >= 0) begin
            res.status = STAT_RESOLVED;
            res.mac    = cache_mac[hit];
         end else begin
            res.status = STAT_REQUEST;
         end
      end else begin
         fields_ok = it.msg_len >= ARP_MIN_LEN && it.hw_type == ARP_HTYPE_ETHERNET &&
                     it.ptype == ARP_PTYPE_IPV4 && it.target_ip == own_ip;
         if (fields_ok && it.op_code == ARP_OP_REQUEST) begin
            res.status = STAT_REPLY;
            res.mac    = it.sender_mac;
            res.ip     = it.sender_ip;
         end else if (fields_ok && it.op_code == ARP_OP_RESPONSE &&
                      find_entry(it.sender_ip) < 0) begin
            cache_ip[next_slot]  = it.sender_ip;
            cache_mac[next_slot] = it.sender_mac;
            next_slot  = (next_slot + 1) % CACHE_ENTRIES;
            res.status = STAT_UPDATED;
         end
      end
      return res;
   endfunction

   task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      arp_outcome_type want;
      if (reset) begin
         own_ip      = '0;
         subnet_mask = '0;
         gateway_ip  = '0;
         for (int i = 0; i < CACHE_ENTRIES; i++) begin
            cache_ip[i]  = '0;
            cache_mac[i] = '0;
         end
         next_slot = 0;
         awaited_outcomes.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_OWN_IP:      own_ip      = csr_wdata[31:0];
               CSR_OWN_MAC:     ;
               CSR_SUBNET_MASK: subnet_mask = csr_wdata[31:0];
               CSR_GATEWAY_IP:  gateway_ip  = csr_wdata[31:0];
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready) begin
            awaited_outcomes.push_back(arp_outcome('{
               kind:       req_chan.kind,
               dest_ip:    req_chan.dest_ip,
               msg_len:    req_chan.msg_len,
               hw_type:    req_chan.hw_type,
               ptype:      req_chan.ptype,
               op_code:    req_chan.op_code,
               sender_mac: req_chan.sender_mac,
               sender_ip:  req_chan.sender_ip,
               target_ip:  req_chan.target_ip}));
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (awaited_outcomes.size() == 0) begin
               $error("unexpected result: status %0d, mac_out 0x%0h, ip_out 0x%0h",
                      rsp_chan.status, rsp_chan.mac_out, rsp_chan.ip_out);
               fail_count++;
            end else begin
               want = awaited_outcomes.pop_front();
               check_field("status", 48'(want.status), 48'(rsp_chan.status));
               check_field("mac_out", want.mac, rsp_chan.mac_out);
               check_field("ip_out", 48'(want.ip), 48'(rsp_chan.ip_out));
            end
         end
      end
      outstanding = awaited_outcomes.size();
   end

endmodule

/* tb/arp_cache_resolver_test.sv */
`timescale 1ns / 1ps
// Testbench top for the ARP cache resolver: clock, reset, stimulus and verdict.
// Depends on arpc_pkg, arpc_if, the block itself and arp_cache_resolver_checker.
module arp_cache_resolver_test
   import arpc_pkg::*;
();

   localparam int RANDOM_ITEMS  = 700;
   localparam int PHASES        = 4;
   localparam int POOL_SIZE     = 12;
   localparam int SETTLE_CYCLES = 24;
   // Slowest run is roughly 730 items; allow ample margin.
   localparam int LIMIT_CYCLES  = 250000;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [47:0] csr_wdata;

   int fail_count;
   int outstanding;
   int stall_pct;
   int cycle_count = 0;

   // Current register settings, kept here only to shape the stimulus.
   logic [31:0] cfg_own_ip;
   logic [31:0] cfg_mask;
   logic [31:0] cfg_gateway;
   logic [31:0] peer_ip [POOL_SIZE];

   arpc_req_if req_chan ();
   arpc_rsp_if rsp_chan ();

   arp_cache_resolver dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   arp_cache_resolver_checker result_check (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Stall the result side at random; hold ready low through reset.
   always @(posedge clock) begin
      rsp_chan.ready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   // Give up on a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Fill every field at random; the helpers below overwrite what matters.
   function automatic req_item_type noise_item();
      req_item_type it;
      it.kind       = 1'($urandom);
      it.dest_ip    = $urandom;
      it.msg_len    = 11'($urandom);
      it.hw_type    = 16'($urandom);
      it.ptype      = 16'($urandom);
      it.op_code    = 16'($urandom);
      it.sender_mac = {16'($urandom), $urandom};
      it.sender_ip  = $urandom;
      it.target_ip  = $urandom;
      return it;
   endfunction

   function automatic req_item_type resolve_item(logic [31:0] dest);
      req_item_type it;
      it         = noise_item();
      it.kind    = 1'b0;
      it.dest_ip = dest;
      return it;
   endfunction

   // Well-formed ARP message addressed to this node.
   function automatic req_item_type arp_item(logic [15:0] op, logic [31:0] sip,
                                             logic [47:0] smac);
      req_item_type it;
      it            = noise_item();
      it.kind       = 1'b1;
      it.msg_len    = 11'($urandom_range(2047, 28));
      it.hw_type    = ARP_HTYPE_ETHERNET;
      it.ptype      = ARP_PTYPE_IPV4;
      it.op_code    = op;
      it.sender_ip  = sip;
      it.sender_mac = smac;
      it.target_ip  = cfg_own_ip;
      return it;
   endfunction

   function automatic logic [15:0] random_op();
      return ($urandom_range(1) == 0) ? ARP_OP_REQUEST : ARP_OP_RESPONSE;
   endfunction

   // Mostly well-formed traffic around a small pool of peers, plus broken and noise items.
   function automatic req_item_type random_item();
      req_item_type it;
      int           pick;
      logic [31:0]  dest;
      pick = $urandom_range(99);
      if (pick < 32) begin
         case ($urandom_range(3))
            0:       dest = $urandom;
            1:       dest = cfg_gateway;
            default: dest = peer_ip[$urandom_range(POOL_SIZE - 1)];
         endcase
         it = resolve_item(dest);
      end else if (pick < 45) begin
         it = arp_item(ARP_OP_REQUEST, $urandom, {16'($urandom), $urandom});
      end else if (pick < 75) begin
         it = arp_item(ARP_OP_RESPONSE, peer_ip[$urandom_range(POOL_SIZE - 1)],
                       {16'($urandom), $urandom});
      end else if (pick < 90) begin
         // Spoil exactly one of the acceptance checks.
         it = arp_item(random_op(), peer_ip[$urandom_range(POOL_SIZE - 1)],
                       {16'($urandom), $urandom});
         case ($urandom_range(4))
            0: it.msg_len   = 11'($urandom_range(27));
            1: it.hw_type   = ARP_HTYPE_ETHERNET ^ 16'($urandom_range(16'hFFFF, 1));
            2: it.ptype     = ARP_PTYPE_IPV4 ^ 16'($urandom_range(16'hFFFF, 1));
            3: it.target_ip = cfg_own_ip ^ $urandom_range(32'hFFFF_FFFF, 1);
            default: it.op_code = 16'($urandom);
         endcase
      end else begin
         it = noise_item();
      end
      return it;
   endfunction

   // Offer one item after a random gap and return once it is accepted.
   // Valid stays high on return so back-to-back items never toggle it in one step.
   task automatic send_item(req_item_type it);
      while ($urandom_range(99) < stall_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.kind       <= it.kind;
      req_chan.dest_ip    <= it.dest_ip;
      req_chan.msg_len    <= it.msg_len;
      req_chan.hw_type    <= it.hw_type;
      req_chan.ptype      <= it.ptype;
      req_chan.op_code    <= it.op_code;
      req_chan.sender_mac <= it.sender_mac;
      req_chan.sender_ip  <= it.sender_ip;
      req_chan.target_ip  <= it.target_ip;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Drop valid and hold off until every expected result has come back.
   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_reg(csr_index_type idx, logic [47:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // Reprogram all registers on an idle block and build a fresh peer pool.
   task automatic configure(logic [31:0] own, logic [47:0] mac, logic [31:0] mask,
                            logic [31:0] gw);
      drain();
      write_reg(CSR_OWN_IP, 48'(own));
      write_reg(CSR_OWN_MAC, mac);
      write_reg(CSR_SUBNET_MASK, 48'(mask));
      write_reg(CSR_GATEWAY_IP, 48'(gw));
      cfg_own_ip  = own;
      cfg_mask    = mask;
      cfg_gateway = gw;
      // Even slots on the local subnet, odd slots anywhere, slot zero the gateway.
      for (int i = 0; i < POOL_SIZE; i++) begin
         peer_ip[i] = (i % 2 == 0) ? ((own & mask) | ($urandom & ~mask)) : $urandom;
      end
      peer_ip[0] = gw;
   endtask

   initial begin
      req_item_type it;
      int           prefix;
      logic [31:0]  mask;

      reset               = 1'b1;
      stall_pct           = 18;
      csr_we              = 1'b0;
      csr_index           = CSR_OWN_IP;
      csr_wdata           = '0;
      req_chan.valid      = 1'b0;
      req_chan.kind       = 1'b0;
      req_chan.dest_ip    = '0;
      req_chan.msg_len    = '0;
      req_chan.hw_type    = '0;
      req_chan.ptype      = '0;
      req_chan.op_code    = '0;
      req_chan.sender_mac = '0;
      req_chan.sender_ip  = '0;
      req_chan.target_ip  = '0;
      rsp_chan.ready      = 1'b0;
      cfg_own_ip          = '0;
      cfg_mask            = '0;
      cfg_gateway         = '0;
      for (int i = 0; i < POOL_SIZE; i++) peer_ip[i] = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Registers at reset: everything is local and the table holds only zero pairs,
      // so IP zero resolves to MAC zero and a response from IP zero counts as cached.
      send_item(resolve_item(32'd0));
      send_item(resolve_item(32'hFFFF_FFFF));
      send_item(arp_item(ARP_OP_RESPONSE, 32'd0, 48'hFFFF_FFFF_FFFF));

      configure(32'h0A00_0001, 48'h0200_0000_0001, 32'hFFFF_FF00, 32'h0A00_00FE);
      send_item(arp_item(ARP_OP_REQUEST, 32'h0A00_0005, 48'h0011_2233_4455));
      send_item(arp_item(ARP_OP_RESPONSE, 32'h0A00_0005, 48'h0011_2233_4455));
      // Already cached: the MAC must not be refreshed.
      send_item(arp_item(ARP_OP_RESPONSE, 32'h0A00_0005, 48'hFFFF_FFFF_FFFF));
      send_item(resolve_item(32'h0A00_0005));
      // Off-subnet goes to the gateway: miss first, then learn it, then hit.
      send_item(resolve_item(32'h0808_0808));
      send_item(arp_item(ARP_OP_RESPONSE, 32'h0A00_00FE, 48'h00AA_BBCC_DDEE));
      send_item(resolve_item(32'hC0A8_0001));

      // Length limits and each failing acceptance check.
      it = arp_item(ARP_OP_RESPONSE, 32'h0A00_0077, 48'h1);
      it.msg_len = ARP_MIN_LEN - 11'd1;
      send_item(it);
      it = arp_item(ARP_OP_REQUEST, 32'h0A00_0078, 48'h2);
      it.msg_len = ARP_MIN_LEN;
      send_item(it);
      it.msg_len = 11'h7FF;
      send_item(it);
      it.hw_type = 16'd0;
      send_item(it);
      it = arp_item(ARP_OP_REQUEST, 32'h0A00_0079, 48'h3);
      it.ptype = 16'h86DD;
      send_item(it);
      it = arp_item(ARP_OP_REQUEST, 32'h0A00_007A, 48'h4);
      it.target_ip = 32'h0A00_0002;
      send_item(it);
      it = arp_item(16'd0, 32'h0A00_007B, 48'h5);
      send_item(it);
      it.op_code = 16'hFFFF;
      send_item(it);

      // Fill the rest of the table and wrap the write pointer over the oldest entry.
      for (int i = 0; i < ARPC_CACHE_ENTRIES - 1; i++) begin
         send_item(arp_item(ARP_OP_RESPONSE, 32'h0A00_0010 + i, {16'($urandom), $urandom}));
      end
      send_item(resolve_item(32'h0A00_0005));

      // Random traffic over several register settings, extremes among them.
      for (int phase = 0; phase < PHASES; phase++) begin
         prefix = $urandom_range(32);
         mask   = (prefix == 0) ? 32'd0 : (32'hFFFF_FFFF << (32 - prefix));
         case (phase)
            0: configure($urandom, {16'($urandom), $urandom}, 32'hFFFF_0000, $urandom);
            1: configure(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            2: configure(32'd0, 48'd0, 32'd0, 32'd0);
            default: configure($urandom, {16'($urandom), $urandom}, mask, $urandom);
         endcase
         // Run one whole phase with no idling on either side.
         stall_pct = (phase == 1) ? 0 : 18;
         for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
            send_item(random_item());
         end
      end
      stall_pct = 18;

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/arpc_pkg.sv
hw/rtl/arpc_if.sv
hw/rtl/arpc_cell.sv
hw/rtl/arp_cache_resolver.sv
tb/arp_cache_resolver_checker.sv
tb/arp_cache_resolver_test.sv
